// ===== src/stream_compare_first_difference_core_macros.svh =====
// Assertion macros shared by the stream compare RTL.
// Each macro wraps one concurrent assertion clocked on the rising edge and
// held off while the synchronous active-low reset is asserted.
`ifndef STREAM_COMPARE_FIRST_DIFFERENCE_CORE_MACROS_SVH
`define STREAM_COMPARE_FIRST_DIFFERENCE_CORE_MACROS_SVH

// Same-cycle implication.
`define SCFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/scfd_pkg.sv =====
// Package for the stream compare block: widths, status codes and lane types.
// No dependencies; used by every module of the block.
package scfd_pkg;

    localparam int LANES_DEF = 8;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int WORD_BYTES = WORD_W / BYTE_W;
    localparam int CNT_W     = 48;
    localparam int OFS_W     = 47;
    localparam int NB_W      = 4;
    localparam int ST_W      = 2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    localparam logic [ST_W-1:0] ST_RUN  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAME = 2'd1;
    localparam logic [ST_W-1:0] ST_DIFF = 2'd2;

    // What one lane found for its byte pair.
    typedef struct packed {
        logic hit;   // inside both streams and equal
        logic miss;  // inside both streams and different
        logic nl;    // stream A byte is a newline
    } t_lane_flag;

    // One result beat before the position is added up.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] line;
        logic             finished;
    } t_result;

endpackage

// ===== src/scfd_lane.sv =====
// One compare lane: tests one byte pair of the input beat.
// Depends on scfd_pkg.
module scfd_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic [scfd_pkg::WORD_W-1:0] i_word_a,
    input  logic [scfd_pkg::WORD_W-1:0] i_word_b,
    input  logic [scfd_pkg::NB_W-1:0]   i_bytes_a,
    input  logic [scfd_pkg::NB_W-1:0]   i_bytes_b,
    output scfd_pkg::t_lane_flag        o_flag
);
    import scfd_pkg::*;

    localparam int IW = NB_W + 1;

    logic [BYTE_W-1:0] w_byte_a;
    logic [BYTE_W-1:0] w_byte_b;
    logic              w_in_both;

    // Lanes beyond the width of the word see zero bytes.
    generate
        if (LANE_IDX < WORD_BYTES) begin : g_real
            assign w_byte_a = i_word_a[LANE_IDX*BYTE_W +: BYTE_W];
            assign w_byte_b = i_word_b[LANE_IDX*BYTE_W +: BYTE_W];
        end else begin : g_pad
            assign w_byte_a = '0;
            assign w_byte_b = '0;
        end
    endgenerate

    // The lane takes part only while both streams still hold a byte here.
    assign w_in_both = ({1'b0, i_bytes_a} > IW'(LANE_IDX)) &&
                       ({1'b0, i_bytes_b} > IW'(LANE_IDX));

    assign o_flag.hit  = w_in_both && (w_byte_a == w_byte_b);
    assign o_flag.miss = w_in_both && (w_byte_a != w_byte_b);
    assign o_flag.nl   = (w_byte_a == NEWLINE);

endmodule

// ===== src/scfd_merge.sv =====
// Merge stage: combines the lane flags, updates the running counters and
// holds the first result register. Depends on scfd_pkg and the macro header.
`include "stream_compare_first_difference_core_macros.svh"

module scfd_merge #(
    parameter int LANES = scfd_pkg::LANES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_first_word,
    input  logic [scfd_pkg::NB_W-1:0]          i_bytes_a,
    input  logic [scfd_pkg::NB_W-1:0]          i_bytes_b,
    input  scfd_pkg::t_lane_flag [LANES-1:0]   i_lanes,
    input  logic                               i_down_ready,
    output logic                               o_up_ready,
    output logic                               o_valid,
    output scfd_pkg::t_result                  o_result
);
    import scfd_pkg::*;

    localparam int CW = $clog2(LANES + 1);
    localparam int XW = NB_W + 1;

    logic [LANES-1:0] w_hit;
    logic [LANES-1:0] w_miss;
    logic [LANES-1:0] w_nl;
    logic [LANES-1:0] w_prefix;
    logic [CW-1:0]    w_run_len;
    logic [CW-1:0]    w_run_nl;
    logic [CW-1:0]    w_na;
    logic [CW-1:0]    w_nb;
    logic             w_accept;

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [CNT_W-1:0] r_line_count, n_line_count;
    logic             r_done, n_done;
    logic [ST_W-1:0]  r_final_status, n_final_status;
    logic             r_valid;
    t_result          r_result, n_result;

    // Unpack the lane flags and form the run of leading matches.
    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_flag
            assign w_hit[g]    = i_lanes[g].hit;
            assign w_miss[g]   = i_lanes[g].miss;
            assign w_nl[g]     = i_lanes[g].nl;
            assign w_prefix[g] = &w_hit[g:0];
        end
    endgenerate

    assign w_run_len = CW'($countones(w_prefix));
    assign w_run_nl  = CW'($countones(w_prefix & w_nl));

    // Byte counts saturate at the lane count.
    assign w_na = ({1'b0, i_bytes_a} > XW'(LANES)) ? CW'(LANES) : CW'(i_bytes_a);
    assign w_nb = ({1'b0, i_bytes_b} > XW'(LANES)) ? CW'(LANES) : CW'(i_bytes_b);

    // Handshake for the first result register.
    assign o_up_ready = !r_valid || i_down_ready;
    assign w_accept   = i_in_valid && o_up_ready;

    // Next counter state and result for the beat on the input.
    always_comb begin
        logic [CNT_W-1:0] base_count;
        logic [CNT_W-1:0] base_line;
        logic             base_done;
        logic [ST_W-1:0]  base_status;
        base_count  = i_first_word ? '0 : r_byte_count;
        base_line   = i_first_word ? CNT_W'(1) : r_line_count;
        base_done   = i_first_word ? 1'b0 : r_done;
        base_status = i_first_word ? ST_RUN : r_final_status;

        n_byte_count   = base_count;
        n_line_count   = base_line;
        n_done         = base_done;
        n_final_status = base_status;

        if (!base_done) begin
            n_byte_count = base_count + CNT_W'(w_run_len);
            n_line_count = base_line + CNT_W'(w_run_nl);
            if ((|w_miss) || (w_na != w_nb)) begin
                n_done         = 1'b1;
                n_final_status = ST_DIFF;
            end else if (w_na < CW'(LANES)) begin
                n_done         = 1'b1;
                n_final_status = ST_SAME;
            end
        end

        n_result.status   = n_final_status;
        n_result.count    = n_byte_count;
        n_result.line     = n_line_count;
        n_result.finished = n_done;
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_byte_count   <= '0;
            r_line_count   <= CNT_W'(1);
            r_done         <= 1'b0;
            r_final_status <= ST_RUN;
        end else begin
            if (o_up_ready) begin
                r_valid <= i_in_valid;
            end
            if (w_accept) begin
                r_byte_count   <= n_byte_count;
                r_line_count   <= n_line_count;
                r_done         <= n_done;
                r_final_status <= n_final_status;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `SCFD_ASSERT_IMP(a_done_final, i_clk, i_rst_n, r_done,
        (r_final_status == ST_DIFF) || (r_final_status == ST_SAME),
        "done flag set without a final status")
    `SCFD_ASSERT_IMP(a_fin_status, i_clk, i_rst_n, r_valid,
        r_result.finished == (r_result.status != ST_RUN),
        "finished flag disagrees with status")
    `SCFD_ASSERT_NXT(a_repeat_final, i_clk, i_rst_n, w_accept && !i_first_word && r_done,
        r_result.status == $past(r_final_status),
        "final status not repeated after completion")

endmodule

// ===== src/stream_compare_first_difference_core.sv =====
// Top level of the stream compare block: offset register, compare lanes,
// merge stage and output register. Depends on scfd_pkg, scfd_lane, scfd_merge.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    first word, two words, two counts
//  result    out        o_out_valid / i_out_stall  status, position, line, finished
//  config    in         i_cfg_wr_en                start offset (47 bits)
//
// One input beat is taken every cycle unless the input stalls; its result passes
// the merge and output registers; the rate is set by the merge counter update.
// Reset clears the byte count, the done flag, the offset and both valid flags, and sets the line count to one.
// A stalled result holds; the input stalls only when both result registers are full.
`include "stream_compare_first_difference_core_macros.svh"

module stream_compare_first_difference_core #(
    parameter int LANES = scfd_pkg::LANES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [scfd_pkg::OFS_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_first_word,
    input  logic [scfd_pkg::WORD_W-1:0]  i_word_a,
    input  logic [scfd_pkg::WORD_W-1:0]  i_word_b,
    input  logic [scfd_pkg::NB_W-1:0]    i_bytes_a,
    input  logic [scfd_pkg::NB_W-1:0]    i_bytes_b,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [scfd_pkg::ST_W-1:0]    o_status,
    output logic [scfd_pkg::CNT_W-1:0]   o_byte_position,
    output logic [scfd_pkg::CNT_W-1:0]   o_line_count,
    output logic                         o_finished
);
    import scfd_pkg::*;

    t_lane_flag [LANES-1:0] w_lanes;
    t_result                w_s1_result;
    logic                   w_s1_valid;
    logic                   w_s1_ready;
    logic                   w_out_ready;

    logic [OFS_W-1:0] r_start_offset;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [CNT_W-1:0] r_position;
    logic [CNT_W-1:0] r_line;
    logic             r_finished;

    // Start offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
        end else if (i_cfg_wr_en) begin
            r_start_offset <= i_cfg_wr_data;
        end
    end

    // Compare lanes, one per byte pair.
    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            scfd_lane #(
                .LANE_IDX (g)
            ) u_lane (
                .i_word_a  (i_word_a),
                .i_word_b  (i_word_b),
                .i_bytes_a (i_bytes_a),
                .i_bytes_b (i_bytes_b),
                .o_flag    (w_lanes[g])
            );
        end
    endgenerate

    // Merge of the lane flags and counter update.
    scfd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_first_word (i_first_word),
        .i_bytes_a    (i_bytes_a),
        .i_bytes_b    (i_bytes_b),
        .i_lanes      (w_lanes),
        .i_down_ready (w_out_ready),
        .o_up_ready   (w_s1_ready),
        .o_valid      (w_s1_valid),
        .o_result     (w_s1_result)
    );

    assign o_in_stall  = !w_s1_ready;
    assign w_out_ready = !r_out_valid || !i_out_stall;

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_s1_valid;
        end
    end

    // Output payload; the position is the offset plus one plus the byte count.
    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_s1_valid) begin
            r_status   <= w_s1_result.status;
            r_position <= CNT_W'({1'b0, r_start_offset}) + w_s1_result.count + CNT_W'(1);
            r_line     <= w_s1_result.line;
            r_finished <= w_s1_result.finished;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_byte_position = r_position;
    assign o_line_count    = r_line;
    assign o_finished      = r_finished;

    `SCFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid, "result beat dropped while stalled")
    `SCFD_ASSERT_IMP(a_run_open, i_clk, i_rst_n, o_out_valid && !o_finished,
        o_status == ST_RUN, "open result carries a final status")
    `SCFD_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall && w_s1_valid,
        "input stalled while a result register is free")

endmodule
